FILE: hdl/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, constants and round tables for the MD5 digest core.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] IV_A     = 32'h67452301;
    localparam logic [31:0] IV_B     = 32'hefcdab89;
    localparam logic [31:0] IV_C     = 32'h98badcfe;
    localparam logic [31:0] IV_D     = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        W_INPUT,
        W_PAD80,
        W_ZERO,
        W_LEN_LO,
        W_LEN_HI
    } word_sel_t;

    typedef struct packed {
        logic      accept;
        logic      wr_en;
        word_sel_t wr_sel;
        logic      round_init;
        logic      round_en;
        logic [5:0] round_idx;
        logic      chain_add;
        logic      out_load;
    } md5_cmd_t;

    typedef struct packed {
        logic [3:0] word_pos;
        logic       full_word;
        logic       out_free;
    } md5_status_t;

    function automatic logic [31:0] sine_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/md5_message_digest_core.sv
// ----------------------------------------------------------------------------
// MD5 message digest core
// Streams a message in 32-bit little-endian words and returns the 128-bit
// MD5 digest after the last word.
// ----------------------------------------------------------------------------
// Words are accepted one per cycle until a 16-word block is full; the round
// registers load on the same edge as the sixteenth word, and the block then
// occupies the core for 64 rounds on a single round unit and one chaining
// add, during which no words are accepted. After the last word the core writes
// the padding and length words one per cycle, runs one or two more blocks,
// and presents the digest with a as bits 31:0 of m_tdata. The next message
// may start while the digest transaction is still waiting.
module md5_message_digest_core
    import md5_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // message_word
    input  logic [2:0]   s_tuser,   // valid_bytes
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // digest_a, digest_b, digest_c, digest_d
);

    md5_cmd_t    cmd;
    md5_status_t status;

    md5_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    md5_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: hdl/md5_dpath.sv
// ----------------------------------------------------------------------------
// MD5 datapath
// Block word store, round registers, chaining value, bit length and the
// output register.
// ----------------------------------------------------------------------------
module md5_dpath
    import md5_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [31:0]  s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         s_tlast,
    input  md5_cmd_t     cmd,
    output md5_status_t  status,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata
);

    logic [31:0]  block_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [31:0]  ch_a_reg, ch_b_reg, ch_c_reg, ch_d_reg;
    logic [3:0]   pos_reg;
    logic [63:0]  len_reg;
    logic [127:0] out_reg;
    logic         out_valid_reg;

    logic         full_word;
    logic [2:0]   count_eff;
    logic [31:0]  in_word;
    logic [31:0]  wr_word;
    logic [31:0]  f_val;
    logic [3:0]   g_idx;
    logic [3:0]   i4;
    logic [31:0]  f_sum;
    logic [63:0]  rot_wide;
    logic [31:0]  b_next;

    assign full_word = !s_tlast || (s_tuser > 3'd3);
    assign count_eff = full_word ? 3'd4 : s_tuser;

    always_comb
    begin
        case (s_tuser[1:0])
            2'd0:    in_word = {24'h0, PAD_BYTE};
            2'd1:    in_word = {16'h0, PAD_BYTE, s_tdata[7:0]};
            2'd2:    in_word = {8'h0, PAD_BYTE, s_tdata[15:0]};
            default: in_word = {PAD_BYTE, s_tdata[23:0]};
        endcase
        if (full_word)
        begin
            in_word = s_tdata;
        end
    end

    always_comb
    begin
        case (cmd.wr_sel)
            W_INPUT:  wr_word = in_word;
            W_PAD80:  wr_word = {24'h0, PAD_BYTE};
            W_LEN_LO: wr_word = len_reg[31:0];
            W_LEN_HI: wr_word = len_reg[63:32];
            default:  wr_word = 32'h0;
        endcase
    end

    assign i4 = cmd.round_idx[3:0];

    always_comb
    begin
        case (cmd.round_idx[5:4])
            2'd0:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                g_idx = i4;
            end
            2'd1:
            begin
                f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
                g_idx = (i4 << 2) + i4 + 4'd1;
            end
            2'd2:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = (i4 << 1) + i4 + 4'd5;
            end
            default:
            begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = (i4 << 3) - i4;
            end
        endcase
    end

    assign f_sum    = a_reg + f_val + sine_k(cmd.round_idx) + block_reg[g_idx];
    assign rot_wide = {f_sum, f_sum} << rot_amount(cmd.round_idx);
    assign b_next   = b_reg + rot_wide[63:32];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            block_reg[pos_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= 32'h0;
            b_reg         <= 32'h0;
            c_reg         <= 32'h0;
            d_reg         <= 32'h0;
            ch_a_reg      <= IV_A;
            ch_b_reg      <= IV_B;
            ch_c_reg      <= IV_C;
            ch_d_reg      <= IV_D;
            pos_reg       <= 4'd0;
            len_reg       <= 64'h0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                pos_reg <= pos_reg + 4'd1;
            end
            if (cmd.accept)
            begin
                len_reg <= len_reg + {58'h0, count_eff, 3'b000};
            end
            if (cmd.round_init)
            begin
                a_reg <= ch_a_reg;
                b_reg <= ch_b_reg;
                c_reg <= ch_c_reg;
                d_reg <= ch_d_reg;
            end
            else if (cmd.round_en)
            begin
                a_reg <= d_reg;
                b_reg <= b_next;
                c_reg <= b_reg;
                d_reg <= c_reg;
            end
            if (cmd.chain_add)
            begin
                ch_a_reg <= ch_a_reg + a_reg;
                ch_b_reg <= ch_b_reg + b_reg;
                ch_c_reg <= ch_c_reg + c_reg;
                ch_d_reg <= ch_d_reg + d_reg;
            end
            if (cmd.out_load)
            begin
                ch_a_reg      <= IV_A;
                ch_b_reg      <= IV_B;
                ch_c_reg      <= IV_C;
                ch_d_reg      <= IV_D;
                len_reg       <= 64'h0;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= {ch_d_reg, ch_c_reg, ch_b_reg, ch_a_reg};
        end
    end

    assign status.word_pos  = pos_reg;
    assign status.full_word = full_word;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

FILE: hdl/md5_ctrl.sv
// ----------------------------------------------------------------------------
// MD5 controller
// Sequences word intake, padding, the 64 rounds and the digest hand-off.
// ----------------------------------------------------------------------------
module md5_ctrl
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    input  md5_status_t status,
    output md5_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic        pad_mode_reg, pad_mode_next;
    logic        need80_reg, need80_next;
    logic        lo_done_reg, lo_done_next;
    logic        last_blk_reg, last_blk_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            round_reg    <= 6'd0;
            pad_mode_reg <= 1'b0;
            need80_reg   <= 1'b0;
            lo_done_reg  <= 1'b0;
            last_blk_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            pad_mode_reg <= pad_mode_next;
            need80_reg   <= need80_next;
            lo_done_reg  <= lo_done_next;
            last_blk_reg <= last_blk_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        pad_mode_next  = pad_mode_reg;
        need80_next    = need80_reg;
        lo_done_next   = lo_done_reg;
        last_blk_next  = last_blk_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.wr_sel     = W_ZERO;
        cmd.round_idx  = round_reg;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept    = 1'b1;
                    cmd.wr_en     = 1'b1;
                    cmd.wr_sel    = W_INPUT;
                    pad_mode_next = s_tlast;
                    need80_next   = s_tlast && status.full_word;
                    lo_done_next  = 1'b0;
                    last_blk_next = 1'b0;
                    if (status.word_pos == 4'd15)
                    begin
                        cmd.round_init = 1'b1;
                        round_next     = 6'd0;
                        state_next     = S_ROUND;
                    end
                    else if (s_tlast)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                cmd.wr_en = 1'b1;
                if (need80_reg)
                begin
                    cmd.wr_sel  = W_PAD80;
                    need80_next = 1'b0;
                end
                else if (status.word_pos == 4'd15 && lo_done_reg)
                begin
                    cmd.wr_sel    = W_LEN_HI;
                    last_blk_next = 1'b1;
                end
                else if (status.word_pos == 4'd14)
                begin
                    cmd.wr_sel   = W_LEN_LO;
                    lo_done_next = 1'b1;
                end
                if (status.word_pos == 4'd15)
                begin
                    cmd.round_init = 1'b1;
                    round_next     = 6'd0;
                    state_next     = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.chain_add = 1'b1;
                if (last_blk_reg)
                begin
                    state_next = S_DONE;
                end
                else if (pad_mode_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    pad_mode_next = 1'b0;
                    last_blk_next = 1'b0;
                    lo_done_next  = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A write into the last block slot always starts the rounds.
    a_wrap_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && status.word_pos == 4'd15) |=> (state_reg == S_ROUND && round_reg == 6'd0))
        else $error("block wrap did not start the rounds");

    a_rounds_end_in_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && round_reg == 6'd63) |=> cmd.chain_add)
        else $error("round 63 not followed by the chaining add");

    a_len_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_sel == W_LEN_HI) |-> (lo_done_reg && status.word_pos == 4'd15))
        else $error("length high word written out of place");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (status.out_free && status.word_pos == 4'd0))
        else $error("digest loaded over a pending transaction or mid-block");

endmodule
